[rtl/fdrd_pkg.sv]
package fdrd_pkg;

    localparam int FRAME_BYTES_MAX = 16384;

    localparam logic [14:0] FRAME_BYTES_RESET = 15'd12000;
    localparam logic [14:0] FRAME_SIZE_CAP    = 15'(FRAME_BYTES_MAX);

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // header_phase: 0..3 count header bytes, PH_DATA means data bytes follow
    localparam logic [2:0] PH_SKIP_HI = 3'd0;
    localparam logic [2:0] PH_SKIP_LO = 3'd1;
    localparam logic [2:0] PH_CTL_HI  = 3'd2;
    localparam logic [2:0] PH_CTL_LO  = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;

    localparam logic [15:0] HEADER_BYTES = 16'd4;

    typedef enum logic [2:0] {
        ST_BUSY          = 3'd0,
        ST_DONE          = 3'd1,
        ST_TRUNC_HEADER  = 3'd2,
        ST_SKIP_PAST_END = 3'd3,
        ST_BAD_LENGTH    = 3'd4,
        ST_TRUNC_DATA    = 3'd5
    } t_status;

    typedef struct packed {
        logic        command;
        logic [15:0] total_length;
        logic [7:0]  byte_in;
    } t_item;

    typedef struct packed {
        logic        write_valid;
        logic [13:0] frame_offset;
        logic [7:0]  fill_value;
        logic [14:0] run_length;
        t_status     status;
    } t_result;

    // handshake between the pipeline stages
    typedef struct packed {
        logic fire;
        logic has_result;
    } t_stage_ctl;

endpackage

[rtl/fdrd_in_if.sv]
interface fdrd_in_if
    import fdrd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] total_length;
    logic [7:0]  byte_in;

    modport source (output valid, output command, output total_length, output byte_in,
                    input ready);
    modport sink (input valid, input command, input total_length, input byte_in,
                  output ready);
endinterface

[rtl/fdrd_out_if.sv]
interface fdrd_out_if
    import fdrd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [13:0] frame_offset;
    logic [7:0]  fill_value;
    logic [14:0] run_length;
    logic [2:0]  status;

    modport source (output valid, output write_valid, output frame_offset,
                    output fill_value, output run_length, output status, input ready);
    modport sink (input valid, input write_valid, input frame_offset,
                  input fill_value, input run_length, input status, output ready);
endinterface

[rtl/fdrd_in_stage.sv]
module fdrd_in_stage
    import fdrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdrd_in_if.sink       i_in,
    input  t_stage_ctl    i_ctl,
    output t_item         o_item,
    output logic          o_valid
);

    logic  r_valid;
    t_item r_item;

    // take a new beat when empty or when the held one moves on this cycle
    assign i_in.ready = i_rst_n && (!r_valid || i_ctl.fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.command      <= i_in.command;
            r_item.total_length <= i_in.total_length;
            r_item.byte_in      <= i_in.byte_in;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

[rtl/fdrd_engine.sv]
module fdrd_engine
    import fdrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic [14:0] i_frame_bytes,
    output t_result     o_result,
    output logic        o_has_result
);

    logic        r_active,    n_active;
    logic [2:0]  r_phase,     n_phase;
    logic [14:0] r_cursor,    n_cursor;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_skip,      n_skip;
    logic [7:0]  r_ctl_hi,    n_ctl_hi;
    logic        r_repeat,    n_repeat;
    logic [14:0] r_run_left,  n_run_left;

    logic [14:0] frame_size;
    logic [14:0] left_cursor;
    logic [14:0] cursor_skip;
    logic [14:0] left_skip;
    logic [14:0] hdr_run;
    logic [14:0] hdr_need;
    logic [15:0] remaining_dec;
    logic [14:0] data_len;
    t_result     res;
    logic        has_res;

    assign frame_size    = (i_frame_bytes < FRAME_SIZE_CAP) ? i_frame_bytes : FRAME_SIZE_CAP;
    assign left_cursor   = (r_cursor < frame_size) ? frame_size - r_cursor : 15'd0;
    assign cursor_skip   = r_cursor + r_skip[14:0];
    assign left_skip     = (cursor_skip < frame_size) ? frame_size - cursor_skip : 15'd0;
    assign hdr_run       = {r_ctl_hi[6:0], i_item.byte_in};
    assign hdr_need      = r_ctl_hi[7] ? 15'd1 : hdr_run;
    assign remaining_dec = r_remaining - 16'd1;
    assign data_len      = r_repeat ? r_run_left : 15'd1;

    always_comb begin
        n_active    = r_active;
        n_phase     = r_phase;
        n_cursor    = r_cursor;
        n_remaining = r_remaining;
        n_skip      = r_skip;
        n_ctl_hi    = r_ctl_hi;
        n_repeat    = r_repeat;
        n_run_left  = r_run_left;
        res         = '0;
        res.status  = ST_BUSY;
        has_res     = 1'b0;

        if (i_item.command == CMD_BEGIN) begin
            // restart, also in mid-delta
            has_res     = 1'b1;
            n_remaining = i_item.total_length;
            n_phase     = PH_SKIP_HI;
            n_cursor    = '0;
            n_skip      = '0;
            n_ctl_hi    = '0;
            n_repeat    = 1'b0;
            n_run_left  = '0;
            n_active    = (i_item.total_length != 16'd0);
            res.status  = n_active ? ST_BUSY : ST_DONE;
        end else if (r_active) begin
            has_res = 1'b1;
            if (r_phase != PH_DATA) begin
                if (r_phase == PH_SKIP_HI && r_remaining < HEADER_BYTES) begin
                    n_active   = 1'b0;
                    res.status = ST_TRUNC_HEADER;
                end else begin
                    n_remaining = remaining_dec;
                    unique case (r_phase)
                        PH_SKIP_HI: begin
                            n_skip  = {i_item.byte_in, 8'h00};
                            n_phase = PH_SKIP_LO;
                        end
                        PH_SKIP_LO: begin
                            n_skip  = {r_skip[15:8], i_item.byte_in};
                            n_phase = PH_CTL_HI;
                        end
                        PH_CTL_HI: begin
                            n_ctl_hi = i_item.byte_in;
                            n_phase  = PH_CTL_LO;
                        end
                        default: begin
                            // last header byte: check the whole record first
                            n_phase    = PH_DATA;
                            n_repeat   = r_ctl_hi[7];
                            n_run_left = hdr_run;
                            n_cursor   = cursor_skip;
                            priority if (r_skip > {1'b0, left_cursor}) begin
                                n_active   = 1'b0;
                                res.status = ST_SKIP_PAST_END;
                            end else if (hdr_run == 15'd0 || hdr_run > left_skip) begin
                                n_active   = 1'b0;
                                res.status = ST_BAD_LENGTH;
                            end else if ({1'b0, hdr_need} > remaining_dec) begin
                                n_active   = 1'b0;
                                res.status = ST_TRUNC_DATA;
                            end else begin
                                res.status = ST_BUSY;
                            end
                        end
                    endcase
                end
            end else begin
                n_remaining = (r_remaining != 16'd0) ? remaining_dec : r_remaining;
                n_run_left  = (r_repeat || r_run_left == 15'd0) ? 15'd0 : r_run_left - 15'd1;
                n_cursor    = r_cursor + data_len;
                res.write_valid  = 1'b1;
                res.frame_offset = r_cursor[13:0];
                res.fill_value   = i_item.byte_in;
                res.run_length   = data_len;
                if (n_run_left == 15'd0) begin
                    n_phase = PH_SKIP_HI;
                    if (n_remaining == 16'd0) begin
                        n_active   = 1'b0;
                        res.status = ST_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= PH_SKIP_HI;
            r_cursor    <= '0;
            r_remaining <= '0;
            r_skip      <= '0;
            r_ctl_hi    <= '0;
            r_repeat    <= 1'b0;
            r_run_left  <= '0;
        end else if (i_fire) begin
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_cursor    <= n_cursor;
            r_remaining <= n_remaining;
            r_skip      <= n_skip;
            r_ctl_hi    <= n_ctl_hi;
            r_repeat    <= n_repeat;
            r_run_left  <= n_run_left;
        end
    end

    assign o_result     = res;
    assign o_has_result = has_res;

endmodule

[rtl/fdrd_out_stage.sv]
module fdrd_out_stage
    import fdrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage_ctl  i_ctl,
    input  t_result     i_result,
    fdrd_out_if.source  o_out,
    output logic        o_free
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.fire && i_ctl.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_ctl.fire && i_ctl.has_result) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.write_valid  = r_result.write_valid;
    assign o_out.frame_offset = r_result.frame_offset;
    assign o_out.fill_value   = r_result.fill_value;
    assign o_out.run_length   = r_result.run_length;
    assign o_out.status       = r_result.status;

endmodule

[rtl/frame_delta_run_decoder_core.sv]
// Frame delta run decoder.
// Input channel i_in carries one beat per item: command 0 begins a delta of
// total_length bytes, command 1 carries one delta byte in byte_in. Output
// channel o_out carries at most one result per item: an optional write run
// (frame_offset, fill_value, run_length) plus a status code. Bytes taken
// while no delta is active give no result beat.
// The frame size sits in a register written through i_cfg_we/i_cfg_data;
// write it only while the block holds no pending item.
// Each result passes through the input register and then the result
// register before it is offered on o_out.
// Throughput: one item per cycle while the receiver does not stall; the
// record state (cursor, remaining count, run count) updates once per item,
// so there is no gap.
// Reset (i_rst_n low) holds i_in.ready low, empties both registers, clears
// the decode state to idle and sets the frame size to 12000.
// When the receiver stalls, the result register holds its beat, the input
// register still takes items, and i_in.ready drops once it holds an item that
// gives a result, until the result register frees up.
module frame_delta_run_decoder_core
    import fdrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdrd_in_if.sink     i_in,
    fdrd_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_data
);

    logic [14:0] r_frame_bytes;
    t_item       item;
    logic        item_valid;
    t_result     result;
    logic        has_result;
    logic        out_free;
    t_stage_ctl  ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_frame_bytes <= i_cfg_data;
        end
    end

    // advance the held item unless its result would overrun a stalled output
    assign ctl.fire       = item_valid && (!has_result || out_free);
    assign ctl.has_result = has_result;

    fdrd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (ctl),
        .o_item  (item),
        .o_valid (item_valid)
    );

    fdrd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (ctl.fire),
        .i_item        (item),
        .i_frame_bytes (r_frame_bytes),
        .o_result      (result),
        .o_has_result  (has_result)
    );

    fdrd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_result (result),
        .o_out    (o_out),
        .o_free   (out_free)
    );

endmodule
